>>> design/idiv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idiv_pkg
// Shared constants and the per-stage item record of the pipelined divider.
// ----------------------------------------------------------------------------
package idiv_pkg;

  // width of the magnitudes that the recurrence works on (at most DATA_W)
  localparam int WIDTH  = 64;
  // width of the operand and result fields on the ports
  localparam int DATA_W = 64;
  localparam int KIND_W = 2;

  // bit positions inside the kind field
  localparam int KIND_REM_BIT    = 0;
  localparam int KIND_SIGNED_BIT = 1;

  // one item as it travels down the chain of cells
  typedef struct packed {
    logic [WIDTH-1:0] rem;       // partial remainder
    logic [WIDTH-1:0] aq;        // dividend bits still to enter, quotient bits behind
    logic [WIDTH-1:0] dvsr;      // divisor magnitude
    logic             want_rem;
    logic             neg_q;
    logic             neg_r;
    logic             div_zero;
  } item_t;

endpackage
`default_nettype wire

>>> design/idiv_prep.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idiv_prep
// Input stage: decodes the kind, takes operand magnitudes, loads the chain.
// ----------------------------------------------------------------------------
module idiv_prep (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic [idiv_pkg::KIND_W-1:0] in_kind,
  input  wire logic [idiv_pkg::DATA_W-1:0] in_dividend,
  input  wire logic [idiv_pkg::DATA_W-1:0] in_divisor,
  output logic                             in_ready,
  output logic                             out_valid,
  output idiv_pkg::item_t                  out_data,
  input  wire logic                        out_ready
);
  import idiv_pkg::*;

  logic [WIDTH-1:0] a;
  logic [WIDTH-1:0] b;
  logic             is_signed;
  logic             neg_a;
  logic             neg_b;
  item_t            item_next;

  always_comb begin
    a         = in_dividend[WIDTH-1:0];
    b         = in_divisor[WIDTH-1:0];
    is_signed = in_kind[KIND_SIGNED_BIT];
    neg_a     = is_signed & a[WIDTH-1];
    neg_b     = is_signed & b[WIDTH-1];
    item_next.rem      = '0;
    item_next.aq       = neg_a ? (WIDTH'(0) - a) : a;
    item_next.dvsr     = neg_b ? (WIDTH'(0) - b) : b;
    item_next.want_rem = in_kind[KIND_REM_BIT];
    item_next.neg_q    = neg_a ^ neg_b;
    item_next.neg_r    = neg_a;
    item_next.div_zero = (b == '0);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= item_next;
    end
  end

endmodule
`default_nettype wire

>>> design/idiv_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idiv_cell
// One restoring step: shift one dividend bit in, trial subtract, keep or not.
// ----------------------------------------------------------------------------
module idiv_cell (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire idiv_pkg::item_t in_data,
  output logic            in_ready,
  output logic            out_valid,
  output idiv_pkg::item_t out_data,
  input  wire logic       out_ready
);
  import idiv_pkg::*;

  logic             carry;
  logic [WIDTH-1:0] shifted;
  logic [WIDTH:0]   diff;
  logic             take;
  item_t            item_next;

  always_comb begin
    carry     = in_data.rem[WIDTH-1];
    shifted   = {in_data.rem[WIDTH-2:0], in_data.aq[WIDTH-1]};
    // a set carry means the shifted value is at least 2^WIDTH, so no borrow
    diff      = {carry, shifted} - {1'b0, in_data.dvsr};
    take      = !diff[WIDTH];
    item_next = in_data;
    item_next.rem = take ? diff[WIDTH-1:0] : shifted;
    item_next.aq  = {in_data.aq[WIDTH-2:0], take};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= item_next;
    end
  end

endmodule
`default_nettype wire

>>> design/idiv_post.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idiv_post
// Output stage: picks quotient or remainder, applies the sign or gives 0 for a zero divisor, holds result.
// ----------------------------------------------------------------------------
module idiv_post (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire idiv_pkg::item_t             in_data,
  output logic                             in_ready,
  output logic                             out_valid,
  output logic [idiv_pkg::DATA_W-1:0]      out_result,
  input  wire logic                        out_ready
);
  import idiv_pkg::*;

  logic [WIDTH-1:0] pick;
  logic             neg;
  logic [WIDTH-1:0] res_next;

  always_comb begin
    pick = in_data.want_rem ? in_data.rem : in_data.aq;
    neg  = in_data.want_rem ? in_data.neg_r : in_data.neg_q;
    if (in_data.div_zero) begin
      res_next = '0;
    end else if (neg) begin
      res_next = WIDTH'(0) - pick;
    end else begin
      res_next = pick;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_result <= DATA_W'(res_next);
    end
  end

endmodule
`default_nettype wire

>>> design/int64_restoring_divider_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// int64_restoring_divider_top
// Pipelined signed/unsigned 64-bit restoring divider on stream ports.
// ----------------------------------------------------------------------------
// Each transaction carries a dividend and a divisor and, in tuser, the kind:
// 0 unsigned quotient, 1 unsigned remainder, 2 signed quotient, 3 signed
// remainder. Signed kinds divide magnitudes; the quotient is negative when
// the operand signs differ and the remainder follows the dividend's sign.
// Division by zero returns 0. A new transaction is taken every cycle while
// s_tready is high; the pipeline has one input stage, a chain of WIDTH cells
// that each produce one quotient bit, and one output register. Stages hand
// over independently, so empty stages fill while the output is stalled.
module int64_restoring_divider_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [2*idiv_pkg::DATA_W-1:0]   s_tdata,  // dividend, divisor
  input  wire logic [idiv_pkg::KIND_W-1:0]     s_tuser,  // kind
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [idiv_pkg::DATA_W-1:0]          m_tdata   // result
);
  import idiv_pkg::*;

  logic  chain_valid [WIDTH+1];
  logic  chain_ready [WIDTH+1];
  item_t chain_data  [WIDTH+1];

  idiv_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_kind     (s_tuser),
    .in_dividend (s_tdata[DATA_W-1:0]),
    .in_divisor  (s_tdata[2*DATA_W-1:DATA_W]),
    .in_ready    (s_tready),
    .out_valid   (chain_valid[0]),
    .out_data    (chain_data[0]),
    .out_ready   (chain_ready[0])
  );

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    idiv_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_data   (chain_data[i]),
      .in_ready  (chain_ready[i]),
      .out_valid (chain_valid[i+1]),
      .out_data  (chain_data[i+1]),
      .out_ready (chain_ready[i+1])
    );
  end

  idiv_post u_post (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (chain_valid[WIDTH]),
    .in_data    (chain_data[WIDTH]),
    .in_ready   (chain_ready[WIDTH]),
    .out_valid  (m_tvalid),
    .out_result (m_tdata),
    .out_ready  (m_tready)
  );

`ifndef SYNTHESIS
  // a finished division by a nonzero divisor leaves a remainder below the divisor
  a_rem_below_dvsr : assert property (@(posedge clk) disable iff (rst)
    chain_valid[WIDTH] && !chain_data[WIDTH].div_zero
      |-> chain_data[WIDTH].rem < chain_data[WIDTH].dvsr)
    else $error("remainder not below divisor at end of chain");

  // divide by zero must reach the port as zero
  a_zero_div_result : assert property (@(posedge clk) disable iff (rst)
    chain_valid[WIDTH] && chain_ready[WIDTH] && chain_data[WIDTH].div_zero
      |=> m_tvalid && (m_tdata == '0))
    else $error("divide by zero gave a nonzero result");

  // with the output register free the whole chain must accept
  a_ready_when_drained : assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output register");
`endif

endmodule
`default_nettype wire
